// ----- rtl/kadq_pkg.sv -----
package kadq_pkg;

    // Number of descriptors the queue can hold.
    localparam int QUEUE_DEPTH = 64;
    localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int TAG_W       = 16;
    localparam int OCC_W       = 7;
    localparam int DROP_W      = 32;

    // Request opcodes carried in the mode field.
    localparam logic MODE_PUSH = 1'b0;
    localparam logic MODE_POP  = 1'b1;

    typedef logic [PTR_W-1:0]  t_ptr;
    typedef logic [CNT_W-1:0]  t_cnt;
    typedef logic [DROP_W-1:0] t_drop;

    typedef struct packed {
        logic             mode;
        logic [TAG_W-1:0] packet_tag;
        logic             is_keyframe;
        logic             is_video;
    } t_in_item;

    typedef struct packed {
        logic [TAG_W-1:0] tag;
        logic             key;
        logic             vid;
    } t_entry;

    typedef struct packed {
        logic              accepted;
        logic              evicted_valid;
        logic [TAG_W-1:0]  evicted_tag;
        logic              pop_valid;
        logic [TAG_W-1:0]  pop_tag;
        logic              pop_keyframe;
        logic              pop_is_video;
        logic [OCC_W-1:0]  occupancy;
        logic [DROP_W-1:0] dropped_count;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_POP,
        ST_SCAN,
        ST_SHIFT,
        ST_OUT
    } t_state;

    // Circular pointer advance; wraps for any depth, not only powers of two.
    function automatic t_ptr ptr_inc(input t_ptr p);
        if (p == t_ptr'(QUEUE_DEPTH - 1)) begin
            return '0;
        end
        return p + t_ptr'(1);
    endfunction

endpackage

// ----- rtl/kadq_in_if.sv -----
interface kadq_in_if;
    logic                valid;
    logic                ready;
    kadq_pkg::t_in_item  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/kadq_out_if.sv -----
interface kadq_out_if;
    logic                valid;
    logic                ready;
    kadq_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/keyframe_aware_drop_queue.sv -----
// Every result is registered and offered in ST_OUT. A push into a queue with room goes there
// straight after acceptance, a pop through ST_POP, a pop of an empty queue straight too. A push
// into a full queue scans for the oldest non-keyframe in ST_SCAN and then closes the gap in
// ST_SHIFT, moving each later entry down and then storing the request; when every entry is a
// keyframe, ST_SCAN goes to ST_OUT. Throughput: one request at a time; the next is taken once the
// result has been taken. Reset (synchronous, active low) empties the queue and clears the drop counter.
module keyframe_aware_drop_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    kadq_in_if.sink           i_in,
    kadq_out_if.source        o_out
);

    // Control state. The queue is a circular buffer: r_head is the oldest entry and
    // r_tail the next free slot. When full, r_head equals r_tail and r_count tells.
    kadq_pkg::t_state    r_state, n_state;
    kadq_pkg::t_ptr      r_head, n_head;
    kadq_pkg::t_ptr      r_tail, n_tail;
    kadq_pkg::t_cnt      r_count, n_count;
    kadq_pkg::t_drop     r_drop, n_drop;

    // Working registers of the sequencer. r_cur is the scan position during the
    // search and the position of the hole while later entries move down.
    kadq_pkg::t_ptr      r_cur, n_cur;
    kadq_pkg::t_ptr      r_scan_cnt, n_scan_cnt;
    kadq_pkg::t_in_item  r_req, n_req;
    kadq_pkg::t_out_item r_out, n_out;

    // Descriptor memory: one write port, one registered read port.
    kadq_pkg::t_entry    r_mem [kadq_pkg::QUEUE_DEPTH];
    kadq_pkg::t_entry    r_rd_data;
    kadq_pkg::t_ptr      rd_addr;
    kadq_pkg::t_ptr      wr_addr;
    kadq_pkg::t_entry    wr_data;
    logic                wr_en;

    logic                in_fire;
    logic                out_fire;
    logic                is_full;
    logic                scan_last;
    logic                shift_done;
    kadq_pkg::t_drop     drop_sat;

    assign i_in.ready  = (r_state == kadq_pkg::ST_IDLE);
    assign o_out.valid = (r_state == kadq_pkg::ST_OUT);
    assign o_out.data  = r_out;

    assign in_fire    = i_in.valid && i_in.ready;
    assign out_fire   = o_out.valid && o_out.ready;
    assign is_full    = (r_count == kadq_pkg::t_cnt'(kadq_pkg::QUEUE_DEPTH));
    assign scan_last  = (r_scan_cnt == kadq_pkg::t_ptr'(kadq_pkg::QUEUE_DEPTH - 1));
    // The hole has reached the youngest entry once the slot after it is the tail.
    assign shift_done = (kadq_pkg::ptr_inc(r_cur) == r_tail);
    // The drop counter sticks at its maximum.
    assign drop_sat   = (r_drop == '1) ? r_drop : r_drop + kadq_pkg::t_drop'(1);

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            kadq_pkg::ST_IDLE: begin
                if (in_fire) begin
                    if (i_in.data.mode == kadq_pkg::MODE_POP) begin
                        n_state = (r_count != '0) ? kadq_pkg::ST_POP : kadq_pkg::ST_OUT;
                    end else begin
                        n_state = is_full ? kadq_pkg::ST_SCAN : kadq_pkg::ST_OUT;
                    end
                end
            end
            kadq_pkg::ST_POP: begin
                n_state = kadq_pkg::ST_OUT;
            end
            kadq_pkg::ST_SCAN: begin
                if (!r_rd_data.key) begin
                    n_state = kadq_pkg::ST_SHIFT;
                end else if (scan_last) begin
                    n_state = kadq_pkg::ST_OUT;
                end
            end
            kadq_pkg::ST_SHIFT: begin
                if (shift_done) begin
                    n_state = kadq_pkg::ST_OUT;
                end
            end
            kadq_pkg::ST_OUT: begin
                if (out_fire) begin
                    n_state = kadq_pkg::ST_IDLE;
                end
            end
            default: n_state = kadq_pkg::ST_IDLE;
        endcase
    end

    // Datapath and memory control for each state.
    always_comb begin
        n_head     = r_head;
        n_tail     = r_tail;
        n_count    = r_count;
        n_drop     = r_drop;
        n_cur      = r_cur;
        n_scan_cnt = r_scan_cnt;
        n_req      = r_req;
        n_out      = r_out;
        rd_addr    = r_head;
        wr_en      = 1'b0;
        wr_addr    = r_tail;
        wr_data    = '{tag: r_req.packet_tag, key: r_req.is_keyframe, vid: r_req.is_video};

        unique case (r_state)
            kadq_pkg::ST_IDLE: begin
                // The head is read every idle cycle so that a pop or a scan finds
                // the oldest entry waiting in the read register.
                rd_addr = r_head;
                if (in_fire) begin
                    n_req               = i_in.data;
                    n_out               = '0;
                    n_out.occupancy     = kadq_pkg::OCC_W'(r_count);
                    n_out.dropped_count = r_drop;
                    if (i_in.data.mode == kadq_pkg::MODE_PUSH) begin
                        if (!is_full) begin
                            wr_en           = 1'b1;
                            wr_addr         = r_tail;
                            wr_data         = '{tag: i_in.data.packet_tag,
                                                key: i_in.data.is_keyframe,
                                                vid: i_in.data.is_video};
                            n_tail          = kadq_pkg::ptr_inc(r_tail);
                            n_count         = r_count + kadq_pkg::t_cnt'(1);
                            n_out.accepted  = 1'b1;
                            n_out.occupancy = kadq_pkg::OCC_W'(r_count + kadq_pkg::t_cnt'(1));
                        end else begin
                            n_cur      = r_head;
                            n_scan_cnt = '0;
                        end
                    end
                end
            end
            kadq_pkg::ST_POP: begin
                n_out.pop_valid    = 1'b1;
                n_out.pop_tag      = r_rd_data.tag;
                n_out.pop_keyframe = r_rd_data.key;
                n_out.pop_is_video = r_rd_data.vid;
                n_head             = kadq_pkg::ptr_inc(r_head);
                n_count            = r_count - kadq_pkg::t_cnt'(1);
                n_out.occupancy    = kadq_pkg::OCC_W'(r_count - kadq_pkg::t_cnt'(1));
            end
            kadq_pkg::ST_SCAN: begin
                // The read register holds the entry at r_cur; the next one is fetched
                // in the same cycle so the search moves one entry per cycle.
                rd_addr = kadq_pkg::ptr_inc(r_cur);
                if (!r_rd_data.key) begin
                    n_out.evicted_valid = 1'b1;
                    n_out.evicted_tag   = r_rd_data.tag;
                    n_drop              = drop_sat;
                end else if (scan_last) begin
                    // Every entry is a keyframe: the new descriptor is the drop.
                    n_drop              = drop_sat;
                    n_out.dropped_count = drop_sat;
                end else begin
                    n_cur      = kadq_pkg::ptr_inc(r_cur);
                    n_scan_cnt = r_scan_cnt + kadq_pkg::t_ptr'(1);
                end
            end
            kadq_pkg::ST_SHIFT: begin
                // The read register holds the entry just behind the hole.
                rd_addr = kadq_pkg::ptr_inc(kadq_pkg::ptr_inc(r_cur));
                wr_en   = 1'b1;
                wr_addr = r_cur;
                if (shift_done) begin
                    // The hole is now the youngest slot, which takes the new request.
                    // Occupancy and tail are where they were before the request.
                    n_out.accepted      = 1'b1;
                    n_out.dropped_count = r_drop;
                end else begin
                    wr_data = r_rd_data;
                    n_cur   = kadq_pkg::ptr_inc(r_cur);
                end
            end
            kadq_pkg::ST_OUT: begin
                rd_addr = r_head;
            end
            default: begin
                rd_addr = r_head;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= kadq_pkg::ST_IDLE;
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
            r_drop  <= '0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
            r_drop  <= n_drop;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur      <= n_cur;
        r_scan_cnt <= n_scan_cnt;
        r_req      <= n_req;
        r_out      <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd_data <= r_mem[rd_addr];
    end

endmodule
